/* hw/rtl/isrt_pkg.sv */
package isrt_pkg;

	// Capacity of the sorted store, in values.
	localparam int unsigned MAX_ITEMS = 64;
	// Fill count width: holds 0 through MAX_ITEMS.
	localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int unsigned DATA_W    = 32;

	typedef enum logic [0:0] {
		ST_FILL,
		ST_EMIT
	} isrt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;  // insert the offered value into the store
		logic drop;    // offered value did not fit; remember the overflow
		logic pop;     // result taken; shift the store down one place
		logic clear;   // run finished; empty the store for the next set
	} isrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;      // store holds MAX_ITEMS values
		logic one_left;  // one result remains in the current run
	} isrt_stat_t;

endpackage

/* hw/rtl/isrt_ctrl.sv */
module isrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_ready,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_ready,
	input  isrt_pkg::isrt_stat_t stat,
	output isrt_pkg::isrt_cmd_t  cmd
);
	import isrt_pkg::*;

	isrt_state_t state_q;
	isrt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		value_ready  = 1'b0;
		result_valid = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_FILL: begin
				value_ready = 1'b1;
				if (value_valid) begin
					cmd.insert = !stat.full;
					cmd.drop   = stat.full;
					if (last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					cmd.pop = 1'b1;
					if (stat.one_left) begin
						cmd.clear = 1'b1;
						state_d   = ST_FILL;
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

endmodule

/* hw/rtl/isrt_datapath.sv */
module isrt_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [isrt_pkg::DATA_W-1:0]  value,
	input  isrt_pkg::isrt_cmd_t                 cmd,
	output isrt_pkg::isrt_stat_t                stat,
	output logic signed [isrt_pkg::DATA_W-1:0]  sorted_value,
	output logic                                final_res,
	output logic                                overflow
);
	import isrt_pkg::*;

	logic signed [DATA_W-1:0] store_q [MAX_ITEMS];
	logic [CNT_W-1:0]         fill_q;
	logic                     dropped_q;
	logic [MAX_ITEMS-1:0]     take;

	// A cell takes new data when it lies at or above the fill point, or when
	// its entry is strictly greater than the new value. Equal entries stay put,
	// which keeps the sort stable.
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			take[i] = (CNT_W'(i) >= fill_q) || (value < store_q[i]);
		end
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [DATA_W-1:0] ins_data;
		logic signed [DATA_W-1:0] pop_data;

		if (i == 0) begin : g_first
			assign ins_data = value;
		end else begin : g_rest
			assign ins_data = take[i-1] ? store_q[i-1] : value;
		end

		if (i == MAX_ITEMS - 1) begin : g_top
			assign pop_data = store_q[i];
		end else begin : g_below
			assign pop_data = store_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert && take[i]) begin
				store_q[i] <= ins_data;
			end else if (cmd.pop) begin
				store_q[i] <= pop_data;
			end
		end
	end

	// The fill count doubles as the number of results left while a run drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				fill_q    <= '0;
				dropped_q <= 1'b0;
			end else begin
				if (cmd.insert) begin
					fill_q <= fill_q + CNT_W'(1);
				end else if (cmd.pop) begin
					fill_q <= fill_q - CNT_W'(1);
				end
				if (cmd.drop) begin
					dropped_q <= 1'b1;
				end
			end
		end
	end

	assign stat.full     = (fill_q == CNT_W'(MAX_ITEMS));
	assign stat.one_left = (fill_q == CNT_W'(1));

	assign sorted_value = store_q[0];
	assign final_res    = stat.one_left;
	assign overflow     = dropped_q;

endmodule

/* hw/rtl/insertion_sorter_core.sv */
// Stable insertion sorter for sets of signed 32-bit values. Values arrive one
// per transfer on the value channel; the value that carries last closes the set.
// While a set is filling, one value is taken every cycle: each store cell
// compares its entry with the new value in parallel and every entry strictly
// greater moves up one place, so equal values keep their arrival order. After
// the closing value the block drains the set in ascending order on the result
// channel, one result per cycle when result_ready is high, with final_res on
// the last result and overflow on every result when values were dropped. The
// value channel is stalled while a run drains; the drain advances as the
// store shifts down one place per result transfer. At most MAX_ITEMS (64)
// values are kept; further values of the same set are dropped, the closing
// value included, and the run is still emitted.
module insertion_sorter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                value_valid,
	output logic                                value_ready,
	input  logic signed [isrt_pkg::DATA_W-1:0]  value,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [isrt_pkg::DATA_W-1:0]  sorted_value,
	output logic                                final_res,
	output logic                                overflow
);
	import isrt_pkg::*;

	isrt_cmd_t  cmd;
	isrt_stat_t stat;

	// Controller: fill and drain sequencing, handshake control.
	isrt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.value_valid  (value_valid),
		.value_ready  (value_ready),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Datapath: the row of compare-and-shift cells plus fill and drop state.
	// The lowest cell drives the result payload directly.
	isrt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.stat         (stat),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import isrt_pkg::*;

	localparam int unsigned DW = DATA_W;
	localparam logic signed [DW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
	// Watchdog bound in cycles; it leaves wide margin over the slowest legal run.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles the receiver refuses results during the long hold-off.
	localparam int HOLD_CYCLES = 400;
	// Quiet cycles after the last expected result, to catch a stray result.
	localparam int TAIL_CYCLES = 16;

	typedef logic signed [DW-1:0] word_list_t[$];

	// One sorted output as the block should present it.
	typedef struct packed {
		logic signed [DW-1:0] v;
		logic                 fin;
		logic                 ovf;
	} sort_result_t;

	// Keeps its own copy of the set being filled, in ascending order, and the
	// queue of results that the closed sets still owe.
	class sort_board;
		logic signed [DW-1:0] open_set[$];
		bit                   dropped;
		sort_result_t         due_results[$];
		int                   errors;
		int                   sets_closed;
		int                   overflow_sets;
		int                   results_checked;

		// An accepted value goes in after every entry that is not greater,
		// which keeps equal values in arrival order.
		function void insert_value(logic signed [DW-1:0] v, logic l);
			int           pos;
			sort_result_t r;
			if (open_set.size() < MAX_ITEMS) begin
				pos = open_set.size();
				while (pos > 0 && v < open_set[pos-1])
					pos--;
				open_set.insert(pos, v);
			end else begin
				dropped = 1'b1;
			end
			if (l) begin
				foreach (open_set[k]) begin
					r.v   = open_set[k];
					r.fin = (k == open_set.size() - 1);
					r.ovf = dropped;
					due_results.push_back(r);
				end
				sets_closed++;
				if (dropped)
					overflow_sets++;
				open_set.delete();
				dropped = 1'b0;
			end
		endfunction

		function void check_output(logic signed [DW-1:0] v, logic f, logic o);
			sort_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, got value %0d final %0b overflow %0b",
					$time, v, f, o);
				errors++;
			end else begin
				want = due_results.pop_front();
				results_checked++;
				if (v !== want.v) begin
					$display("%0t: sorted_value expected %0d, got %0d", $time, want.v, v);
					errors++;
				end
				if (f !== want.fin) begin
					$display("%0t: final_res expected %0b, got %0b", $time, want.fin, f);
					errors++;
				end
				if (o !== want.ovf) begin
					$display("%0t: overflow expected %0b, got %0b", $time, want.ovf, o);
					errors++;
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 value_valid = 1'b0;
	logic                 value_ready;
	logic signed [DW-1:0] value = '0;
	logic                 last = 1'b0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic signed [DW-1:0] sorted_value;
	logic                 final_res;
	logic                 overflow;

	sort_board board = new();
	// Shared with the result sink: calm turns idling off on both sides, and
	// hold_request asks the sink to start its long hold-off.
	bit        calm = 1'b0;
	bit        hold_request = 1'b0;
	int        items_sent = 0;
	int        cycles = 0;

	insertion_sorter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.value_valid  (value_valid),
		.value_ready  (value_ready),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycles, board.due_results.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Mix of extremes, a narrow band that produces many equal values, and
	// fully random words so every bit of the value toggles.
	function automatic logic signed [DW-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: return int'($urandom_range(0, 8)) - 4;
			default: return $urandom();
		endcase
	endfunction

	// Offers one value and returns in the time step of its transfer, leaving
	// valid high so that a following offer keeps the channel busy.
	task automatic offer_value(input logic signed [DW-1:0] v, input logic l);
		if (!calm && $urandom_range(0, 99) < 36) begin
			value_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 36);
		end
		value_valid <= 1'b1;
		value       <= v;
		last        <= l;
		do @(posedge clk); while (!value_ready);
		board.insert_value(v, l);
		items_sent++;
	endtask

	task automatic send_list(input word_list_t vals);
		foreach (vals[k])
			offer_value(vals[k], k == vals.size() - 1);
	endtask

	task automatic send_random_set(input int len);
		for (int k = 0; k < len; k++)
			offer_value(rand_value(), k == len - 1);
	endtask

	// Sender stands still until every owed result has been taken.
	task automatic pause_until_drained();
		value_valid <= 1'b0;
		do @(posedge clk); while (board.due_results.size() != 0);
	endtask

	// Result sink: checks each transfer against the oldest owed result, then
	// picks the next ready level. The long hold-off is counted here.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				board.check_output(sorted_value, final_res, overflow);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= calm || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	initial begin : stimulus
		word_list_t vals;
		int         set_no;
		int         len;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes and duplicates of both, zero and its neighbors.
		vals = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MAX, VAL_MIN, -1};
		send_list(vals);
		// A set of one value, closed at once.
		vals = '{7};
		send_list(vals);
		// Strictly falling values: every insert shifts the whole store.
		vals = '{3, 2, 1, 0, -1};
		send_list(vals);
		vals = '{VAL_MIN};
		send_list(vals);
		// Already ascending: nothing moves.
		vals = '{-3, 10, 100};
		send_list(vals);

		// Two values past full: the store passes through exactly full, then one
		// value is dropped mid-set and the closing one is dropped too. The sink
		// holds off meanwhile, so the drain stalls and the first random set
		// below backs up at the input with valid held high.
		hold_request = 1'b1;
		send_random_set(MAX_ITEMS + 2);

		// Random sets, mostly short. A stretch of sets runs with no idling on
		// either side, and now and then the sender waits for the drain.
		set_no = 0;
		while (items_sent < 150) begin
			calm = (set_no >= 2 && set_no < 8);
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(20, 40);
			else
				len = $urandom_range(1, 8);
			send_random_set(len);
			if (set_no == 1 || $urandom_range(0, 7) == 0)
				pause_until_drained();
			set_no++;
		end

		calm = 1'b1;
		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d values in %0d sets (%0d with dropped values)",
			items_sent, board.sets_closed, board.overflow_sets);
		$display("checked %0d sorted results, including a long result stall",
			board.results_checked);
		if (board.errors == 0 && board.due_results.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/isrt_pkg.sv
hw/rtl/isrt_ctrl.sv
hw/rtl/isrt_datapath.sv
hw/rtl/insertion_sorter_core.sv
tb/testbench.sv
